// ===== src/lfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types and constants for the four-lane LED driver frame serializer.
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam int WORD_BITS = 16;
  localparam int LANES     = 4;
  localparam int HDR_WORDS = 3;
  localparam int SHIFT_W   = HDR_WORDS * WORD_BITS;
  localparam int CNT_W     = 7;
  localparam int REQ_W     = 2;
  localparam int ICS_DEF   = 4;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CONT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SINGLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DATA   = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  // Per-bit flags that travel with the lane bits to the output stage
  typedef struct packed {
    logic first_bit;
    logic frame_end;
    logic last;
  } lfs_flags_t;

endpackage

// ===== src/lfs_if.sv =====
// ----------------------------------------------------------------------------
// lfs_if
// Valid/ready channels for request words and serial bit words.
// ----------------------------------------------------------------------------
interface lfs_in_if import lfs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  word_t            dev_word;
  logic [CNT_W-1:0] word_count;
  word_t            reg_word;
  word_t            lane0_data;
  word_t            lane1_data;
  word_t            lane2_data;
  word_t            lane3_data;

  modport source (
    output valid, req_type, dev_word, word_count, reg_word,
           lane0_data, lane1_data, lane2_data, lane3_data,
    input  ready
  );
  modport sink (
    input  valid, req_type, dev_word, word_count, reg_word,
           lane0_data, lane1_data, lane2_data, lane3_data,
    output ready
  );
endinterface

interface lfs_out_if import lfs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [LANES-1:0] lane_bits;
  logic             first_bit;
  logic             frame_end;
  logic             last;

  modport source (
    output valid, lane_bits, first_bit, frame_end, last,
    input  ready
  );
  modport sink (
    input  valid, lane_bits, first_bit, frame_end, last,
    output ready
  );
endinterface

// ===== src/lfs_lane.sv =====
// ----------------------------------------------------------------------------
// lfs_lane
// One data lane: loads up to three words and shifts them out MSB first.
// ----------------------------------------------------------------------------
module lfs_lane import lfs_pkg::*; (
  input  logic               clk,
  input  logic               load,
  input  logic               hdr_sel,
  input  logic [SHIFT_W-1:0] hdr_vec,
  input  word_t              data_word,
  input  logic               shift,
  output logic               lane_bit
);

  logic [SHIFT_W-1:0] sreg_r;
  logic [SHIFT_W-1:0] sreg_nxt;

  // Pick header words or this lane's data word, else shift in zeros
  always_comb begin
    sreg_nxt = sreg_r;
    if (load) begin
      sreg_nxt = hdr_sel ? hdr_vec : {data_word, {(SHIFT_W-WORD_BITS){1'b0}}};
    end else if (shift) begin
      sreg_nxt = {sreg_r[SHIFT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    sreg_r <= sreg_nxt;
  end

  assign lane_bit = sreg_r[SHIFT_W-1];

endmodule

// ===== src/lfs_merge.sv =====
// ----------------------------------------------------------------------------
// lfs_merge
// Output stage: gathers the lane bits and flags into one registered word.
// ----------------------------------------------------------------------------
module lfs_merge import lfs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [LANES-1:0] lane_bits,
  input  lfs_flags_t       flags,
  output logic             free,
  lfs_out_if.source        out_ch
);

  logic             valid_r;
  logic [LANES-1:0] bits_r;
  lfs_flags_t       flags_r;

  // Hold the word until taken; accept a new one when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bits_r  <= lane_bits;
      flags_r <= flags;
    end
  end

  assign free             = !valid_r || out_ch.ready;
  assign out_ch.valid     = valid_r;
  assign out_ch.lane_bits = bits_r;
  assign out_ch.first_bit = flags_r.first_bit;
  assign out_ch.frame_end = flags_r.frame_end;
  assign out_ch.last      = flags_r.last;

endmodule

// ===== src/four_lane_led_driver_frame_serializer_core.sv =====
// ----------------------------------------------------------------------------
// Four-lane LED driver frame serializer. One bit per clock on all lanes
// while the output stage can take it: 48/32 bits per header, 16 per data
// word, 16*ICS for the final data word; ignored words are dropped.
// Synchronous active-low reset closes any transaction and empties the output.
// ----------------------------------------------------------------------------
module four_lane_led_driver_frame_serializer_core import lfs_pkg::*; #(
  parameter int ICS = ICS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lfs_in_if.sink    in_ch,
  lfs_out_if.source out_ch
);

  localparam int MAX_BITS = (WORD_BITS * ICS > SHIFT_W) ? WORD_BITS * ICS : SHIFT_W;
  localparam int BL_W     = $clog2(MAX_BITS + 1);
  localparam logic [BL_W-1:0] LEN_CONT   = BL_W'(HDR_WORDS * WORD_BITS);
  localparam logic [BL_W-1:0] LEN_SINGLE = BL_W'(2 * WORD_BITS);
  localparam logic [BL_W-1:0] LEN_DATA   = BL_W'(WORD_BITS);
  localparam logic [BL_W-1:0] LEN_FINAL  = BL_W'(WORD_BITS * ICS);

  logic             open_r, open_nxt;
  logic [CNT_W-1:0] words_left_r, words_left_nxt;
  logic [BL_W-1:0]  bits_left_r, bits_left_nxt;
  logic             first_pend_r, first_pend_nxt;
  logic             frame_end_r, frame_end_nxt;

  logic             in_fire;
  logic             adv;
  logic             free;
  logic             load;
  logic             hdr_sel;
  logic [SHIFT_W-1:0] hdr_vec;
  logic [CNT_W-1:0] wl_dec;
  logic [LANES-1:0] lane_bits;
  word_t            lane_data [LANES];
  lfs_flags_t       flags;

  // Emit a bit whenever one is pending and the output stage can take it
  assign adv         = (bits_left_r != '0) && free;
  assign in_ch.ready = (bits_left_r == '0) || ((bits_left_r == BL_W'(1)) && adv);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign wl_dec      = words_left_r - CNT_W'(1);

  // Decide what an accepted word starts, update transaction state
  always_comb begin
    open_nxt       = open_r;
    words_left_nxt = words_left_r;
    bits_left_nxt  = adv ? bits_left_r - BL_W'(1) : bits_left_r;
    first_pend_nxt = adv ? 1'b0 : first_pend_r;
    frame_end_nxt  = frame_end_r;
    load           = 1'b0;
    hdr_sel        = 1'b1;
    hdr_vec        = {in_ch.dev_word, in_ch.reg_word, {WORD_BITS{1'b0}}};
    if (in_fire) begin
      case (in_ch.req_type)
        REQ_CONT: begin
          hdr_vec = {in_ch.dev_word, WORD_BITS'(in_ch.word_count), in_ch.reg_word};
          if (!open_r && (in_ch.word_count != '0)) begin
            load           = 1'b1;
            open_nxt       = 1'b1;
            words_left_nxt = in_ch.word_count;
            bits_left_nxt  = LEN_CONT;
            first_pend_nxt = 1'b1;
            frame_end_nxt  = 1'b0;
          end
        end
        REQ_SINGLE: begin
          if (!open_r) begin
            load           = 1'b1;
            open_nxt       = 1'b1;
            words_left_nxt = CNT_W'(1);
            bits_left_nxt  = LEN_SINGLE;
            first_pend_nxt = 1'b1;
            frame_end_nxt  = 1'b0;
          end
        end
        REQ_DATA: begin
          hdr_sel = 1'b0;
          if (open_r) begin
            load           = 1'b1;
            words_left_nxt = wl_dec;
            first_pend_nxt = 1'b0;
            if (wl_dec == '0) begin
              open_nxt      = 1'b0;
              bits_left_nxt = LEN_FINAL;
              frame_end_nxt = 1'b1;
            end else begin
              bits_left_nxt = LEN_DATA;
              frame_end_nxt = 1'b0;
            end
          end
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r       <= 1'b0;
      words_left_r <= '0;
      bits_left_r  <= '0;
      first_pend_r <= 1'b0;
      frame_end_r  <= 1'b0;
    end else begin
      open_r       <= open_nxt;
      words_left_r <= words_left_nxt;
      bits_left_r  <= bits_left_nxt;
      first_pend_r <= first_pend_nxt;
      frame_end_r  <= frame_end_nxt;
    end
  end

  assign lane_data[0] = in_ch.lane0_data;
  assign lane_data[1] = in_ch.lane1_data;
  assign lane_data[2] = in_ch.lane2_data;
  assign lane_data[3] = in_ch.lane3_data;

  // One shifter per lane
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    lfs_lane u_lane (
      .clk       (clk),
      .load      (load),
      .hdr_sel   (hdr_sel),
      .hdr_vec   (hdr_vec),
      .data_word (lane_data[k]),
      .shift     (adv),
      .lane_bit  (lane_bits[k])
    );
  end

  // Tag the outgoing bit
  always_comb begin
    flags.first_bit = first_pend_r;
    flags.last      = (bits_left_r == BL_W'(1));
    flags.frame_end = (bits_left_r == BL_W'(1)) && frame_end_r;
  end

  lfs_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .lane_bits (lane_bits),
    .flags     (flags),
    .free      (free),
    .out_ch    (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_open_has_words: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (words_left_r != '0))
    else $error("open transaction with no data words left");

  a_first_needs_bits: assert property (@(posedge clk) disable iff (!rst_n)
    first_pend_r |-> (bits_left_r != '0))
    else $error("first bit pending with nothing to send");

  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bits_left_r <= BL_W'(MAX_BITS))
    else $error("bit counter out of range");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_end) |-> out_ch.last)
    else $error("frame end not on last bit of a word");

  a_fire_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && load) |=> (bits_left_r != '0))
    else $error("loaded word has no bits to send");
`endif

endmodule
